// File: rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/brb_pkg.sv
package brb_pkg;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_DISCARD = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  data_in;
		logic [10:0] amount;
		logic        drop_newest;
	} req_t;

	typedef struct packed {
		logic [7:0]  data_out;
		logic [10:0] moved;
		logic [10:0] stored_count;
		logic [10:0] free_count;
	} rsp_t;

	// Result of one transaction before the popped byte is attached.
	typedef struct packed {
		logic        is_read;
		logic [10:0] moved;
		logic [10:0] stored_count;
		logic [10:0] free_count;
	} res_t;

	localparam int unsigned CAP_RESET = 1024;

endpackage

// File: rtl/core/brb_mem.sv
module brb_mem #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned PW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [PW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [PW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/brb_ctrl.sv
module brb_ctrl #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned PW = $clog2(DEPTH),
	localparam int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [10:0]    cfg_data,
	input  logic           en,
	input  brb_pkg::req_t  item,
	output brb_pkg::res_t  res,
	output logic [CW-1:0]  cap,
	output logic           mem_we,
	output logic [PW-1:0]  mem_waddr,
	output logic [7:0]     mem_wdata,
	output logic           mem_re,
	output logic [PW-1:0]  mem_raddr
);

	localparam int unsigned AW = (CW > 11) ? CW : 11;
	localparam int unsigned CAP_RST =
		(DEPTH < brb_pkg::CAP_RESET) ? DEPTH : brb_pkg::CAP_RESET;

	logic [PW-1:0] wp_q, rp_q, wp_n, rp_n;
	logic          full_q, full_n;
	logic [CW-1:0] cap_q, cap_cfg;
	logic [CW-1:0] count, count_n, moved;
	logic [CW:0]   wp_inc, rp_inc, p_back, p_fwd;
	logic [AW-1:0] amt_w, cnt_w;

	always_comb begin
		if (cfg_data == 11'd0) begin
			cap_cfg = CW'(1);
		end else if (32'(cfg_data) > 32'(DEPTH)) begin
			cap_cfg = CW'(DEPTH);
		end else begin
			cap_cfg = CW'(cfg_data);
		end
	end

	always_comb begin
		if (full_q) begin
			count = cap_q;
		end else if (wp_q >= rp_q) begin
			count = CW'(wp_q) - CW'(rp_q);
		end else begin
			count = cap_q + CW'(wp_q) - CW'(rp_q);
		end

		wp_inc = (CW+1)'(wp_q) + (CW+1)'(1);
		rp_inc = (CW+1)'(rp_q) + (CW+1)'(1);
		amt_w  = AW'(item.amount);
		cnt_w  = AW'(count);

		wp_n   = wp_q;
		rp_n   = rp_q;
		full_n = full_q;
		moved  = '0;
		mem_we = 1'b0;
		p_back = '0;
		p_fwd  = '0;

		unique case (item.op)
			brb_pkg::OP_WRITE: begin
				if (count < cap_q) begin
					wp_n   = (wp_inc >= (CW+1)'(cap_q)) ? '0 : PW'(wp_inc);
					full_n = (wp_n == rp_q);
					moved  = CW'(1);
					mem_we = en;
				end
			end
			brb_pkg::OP_READ: begin
				if (count != '0) begin
					rp_n   = (rp_inc >= (CW+1)'(cap_q)) ? '0 : PW'(rp_inc);
					full_n = 1'b0;
					moved  = CW'(1);
				end
			end
			brb_pkg::OP_DISCARD: begin
				moved  = (amt_w > cnt_w) ? count : CW'(amt_w);
				p_back = (CW+1)'(wp_q) + (CW+1)'(cap_q) - (CW+1)'(moved);
				p_fwd  = (CW+1)'(rp_q) + (CW+1)'(moved);
				if (moved != '0) begin
					if (item.drop_newest) begin
						wp_n = (p_back >= (CW+1)'(cap_q)) ?
							PW'(p_back - (CW+1)'(cap_q)) : PW'(p_back);
					end else begin
						rp_n = (p_fwd >= (CW+1)'(cap_q)) ?
							PW'(p_fwd - (CW+1)'(cap_q)) : PW'(p_fwd);
					end
					full_n = 1'b0;
				end
			end
			brb_pkg::OP_CLEAR: begin
				wp_n   = '0;
				rp_n   = '0;
				full_n = 1'b0;
			end
			default: begin
				wp_n = wp_q;
			end
		endcase

		if (full_n) begin
			count_n = cap_q;
		end else if (wp_n >= rp_n) begin
			count_n = CW'(wp_n) - CW'(rp_n);
		end else begin
			count_n = cap_q + CW'(wp_n) - CW'(rp_n);
		end

		res.is_read      = (item.op == brb_pkg::OP_READ) && (moved != '0);
		res.moved        = 11'(moved);
		res.stored_count = 11'(count_n);
		res.free_count   = 11'(cap_q - count_n);
	end

	assign cap       = cap_q;
	assign mem_waddr = wp_q;
	assign mem_wdata = item.data_in;
	assign mem_re    = en;
	assign mem_raddr = rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			full_q <= 1'b0;
			cap_q  <= CW'(CAP_RST);
		end else if (cfg_we) begin
			wp_q   <= '0;
			rp_q   <= '0;
			full_q <= 1'b0;
			cap_q  <= cap_cfg;
		end else if (en) begin
			wp_q   <= wp_n;
			rp_q   <= rp_n;
			full_q <= full_n;
		end
	end

endmodule

// File: rtl/core/byte_ring_buffer.sv
// Byte ring buffer: a FIFO of DEPTH byte slots, of which cfg_data selects how many are used.
// Requests arrive on req_valid/req_ready as one transaction each: write a byte, read a byte,
// discard up to an amount from the front or the back, or clear. Every request produces
// exactly one response on rsp_valid/rsp_ready with the popped byte, the number of bytes
// moved and the fill level after the request.
// The capacity register is written on cfg_valid/cfg_ready, which is always ready; a write
// also empties the ring. Values of zero act as one and values above DEPTH act as DEPTH.
// An accepted request passes through the result stage and then the output register before
// its response shows. One request is taken per cycle while req_ready is high; that rate
// is set by the single pass of pointer logic and the registered read of the byte memory.
// When the receiver stalls, a result stage and the output register hold up to two
// responses and req_ready falls only when both are occupied.
// Reset empties the ring and sets the capacity to 1024 slots (or DEPTH if smaller).
// Memory contents are not cleared; only bytes written since the last empty are read.
module byte_ring_buffer #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  brb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output brb_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [10:0]   cfg_data
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic          accept, adv;
	logic          valid_s1, rsp_valid_q;
	brb_pkg::res_t res, res_s1;
	brb_pkg::rsp_t rsp_q;
	logic [CW-1:0] cap;
	logic          mem_we, mem_re;
	logic [PW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	assign cfg_ready = 1'b1;
	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || adv;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	brb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.en        (accept),
		.item      (req),
		.res       (res),
		.cap       (cap),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	brb_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (adv && valid_s1) begin
			rsp_q.data_out     <= res_s1.is_read ? mem_rdata : 8'd0;
			rsp_q.moved        <= res_s1.moved;
			rsp_q.stored_count <= res_s1.stored_count;
			rsp_q.free_count   <= res_s1.free_count;
		end
	end

	`include "assert_macros.svh"

	`ASSERT_SAME(a_levels_sum, clk, arst_n, rsp_valid, 11'(rsp.stored_count + rsp.free_count) == 11'(cap))
	`ASSERT_SAME(a_byte_needs_move, clk, arst_n, rsp_valid && (rsp.data_out != 8'd0), rsp.moved == 11'd1)
	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !adv, valid_s1 && $stable(res_s1))

endmodule
